[rtl/float_deque_ring_unit_assert.svh]
// ---------------------------------------------------------------------------
// float_deque_ring_unit assertion macros
// Immediate-implication and next-cycle checks clocked on clk, reset on rst.
// ---------------------------------------------------------------------------
`ifndef FLOAT_DEQUE_RING_UNIT_ASSERT_SVH
`define FLOAT_DEQUE_RING_UNIT_ASSERT_SVH

// check cons in the same cycle as ante
`define FDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define FDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fdr_pkg.sv]
// ---------------------------------------------------------------------------
// fdr_pkg
// Shared operation codes, status codes and float constants of the deque.
// ---------------------------------------------------------------------------
package fdr_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int COUNT_W       = 5;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_NEGATE     = 3'd5,
    OP_ADD_HALF   = 3'd6,
    OP_SUB_ONE    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic [WORD_W-1:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] QUIET_BIT = 32'h0040_0000;
  localparam logic [WORD_W-1:0] F_HALF    = 32'h3F00_0000;
  localparam logic [WORD_W-1:0] F_NEG_ONE = 32'hBF80_0000;

endpackage

[rtl/fdr_ring_mem.sv]
// ---------------------------------------------------------------------------
// fdr_ring_mem
// Ring storage: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module fdr_ring_mem
  import fdr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/fdr_bulk_alu.sv]
// ---------------------------------------------------------------------------
// fdr_bulk_alu
// Two-stage negate / add 0.5 / subtract 1.0 unit, round to nearest even.
// ---------------------------------------------------------------------------
module fdr_bulk_alu
  import fdr_pkg::*;
(
  input  logic              clk,
  input  op_t               op,
  input  logic [WORD_W-1:0] in_word,
  output logic [WORD_W-1:0] out_word
);

  function automatic logic [4:0] lead_zeros(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) begin
        n = 5'(26 - i);
      end
    end
    return n;
  endfunction

  // stage 1: special cases, align, add
  logic [WORD_W-1:0] k;
  logic              a_nan, a_inf, a_big;
  logic [7:0]        ea, eb, e_big, e_sml, align_sh;
  logic [23:0]       ma, mb, m_big, m_sml;
  logic [26:0]       ext, mask, aligned;
  logic [27:0]       sum;
  logic              s_big, eff_sub;

  always_comb begin
    k        = (op == OP_ADD_HALF) ? F_HALF : F_NEG_ONE;
    a_nan    = (in_word[30:23] == 8'hFF) && (in_word[22:0] != '0);
    a_inf    = (in_word[30:23] == 8'hFF) && (in_word[22:0] == '0);
    ea       = (in_word[30:23] == '0) ? 8'd1 : in_word[30:23];
    eb       = (k[30:23] == '0) ? 8'd1 : k[30:23];
    ma       = {in_word[30:23] != '0, in_word[22:0]};
    mb       = {k[30:23] != '0, k[22:0]};
    a_big    = in_word[30:0] >= k[30:0];
    e_big    = a_big ? ea : eb;
    e_sml    = a_big ? eb : ea;
    m_big    = a_big ? ma : mb;
    m_sml    = a_big ? mb : ma;
    s_big    = a_big ? in_word[31] : k[31];
    eff_sub  = in_word[31] ^ k[31];
    align_sh = e_big - e_sml;
    ext      = {m_sml, 3'b000};
    mask     = '0;
    if (align_sh >= 8'd27) begin
      aligned = {26'd0, |m_sml};
    end else begin
      mask    = (27'd1 << align_sh) - 27'd1;
      aligned = (ext >> align_sh) | {26'd0, |(ext & mask)};
    end
    if (eff_sub) begin
      sum = {1'b0, m_big, 3'b000} - {1'b0, aligned};
    end else begin
      sum = {1'b0, m_big, 3'b000} + {1'b0, aligned};
    end
  end

  logic              r_byp;
  logic [WORD_W-1:0] r_byp_word;
  logic              r_sgn;
  logic [7:0]        r_exp;
  logic [27:0]       r_sum;

  always_ff @(posedge clk) begin
    r_sgn <= s_big;
    r_exp <= e_big;
    r_sum <= sum;
    if (op == OP_NEGATE) begin
      r_byp      <= 1'b1;
      r_byp_word <= a_nan ? (in_word | QUIET_BIT) : (in_word ^ SIGN_BIT);
    end else begin
      r_byp      <= a_nan || a_inf;
      r_byp_word <= a_nan ? (in_word | QUIET_BIT) : in_word;
    end
  end

  // stage 2: normalize, round, pack
  logic [4:0]  lz;
  logic [7:0]  max_sh, sh;
  logic [26:0] norm;
  logic [8:0]  e9;
  logic        up;
  logic [24:0] m25;
  logic [23:0] mant;
  logic [WORD_W-1:0] packed_word;

  always_comb begin
    lz     = lead_zeros(r_sum[26:0]);
    max_sh = r_exp - 8'd1;
    sh     = ({3'd0, lz} < max_sh) ? {3'd0, lz} : max_sh;
    if (r_sum[27]) begin
      norm = {r_sum[27:2], r_sum[1] | r_sum[0]};
      e9   = {1'b0, r_exp} + 9'd1;
    end else begin
      norm = r_sum[26:0] << sh;
      e9   = {1'b0, r_exp} - {1'b0, sh};
    end
    up  = norm[2] && (norm[1] || norm[0] || norm[3]);
    m25 = {1'b0, norm[26:3]} + {24'd0, up};
    if (m25[24]) begin
      mant = m25[24:1];
      e9   = e9 + 9'd1;
    end else begin
      mant = m25[23:0];
    end
    if (r_sum == '0) begin
      packed_word = '0;
    end else if (e9 >= 9'd255) begin
      packed_word = {r_sgn, 8'hFF, 23'd0};
    end else begin
      packed_word = {r_sgn, mant[23] ? e9[7:0] : 8'd0, mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    out_word <= r_byp ? r_byp_word : packed_word;
  end

endmodule

[rtl/float_deque_ring_unit.sv]
// ---------------------------------------------------------------------------
// float_deque_ring_unit
// Double-ended queue of single-precision words in a ring memory, with bulk
// negate, add 0.5 and subtract 1.0 over every held entry.
// ---------------------------------------------------------------------------
// One item in, one word out. Push, clear and a pop on an empty queue report
// from IDLE, a pop that finds an entry via POP_WAIT (the ring memory's
// registered read). Bulk operations walk the held entries through the memory
// and the two-stage float unit, entry by entry via BULK_READ, BULK_LOAD,
// BULK_CALC and BULK_WB. Push on full and pop on empty leave the queue
// unchanged and report their status. No clearing pass after reset.
module float_deque_ring_unit
  import fdr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // push_word[31:0]
  input  logic [2:0]  s_tuser,  // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // popped_word[31:0], entry_count[36:32], zero
  output logic [1:0]  m_tuser   // status[1:0]
);

`include "float_deque_ring_unit_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    IDLE, POP_WAIT, BULK_READ, BULK_LOAD, BULK_CALC, BULK_WB
  } state_t;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_t            state;
  logic [AW-1:0]     front;
  logic [CW-1:0]     count, walk;
  op_t               bulk_op;
  logic              res_valid;
  logic [WORD_W-1:0] res_word;
  status_t           res_status;
  logic [CW-1:0]     res_count;

  logic              accept;
  op_t               op_in;
  logic              full, empty;
  logic [AW-1:0]     front_dec, walk_slot;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata, alu_word;

  assign s_tready  = (state == IDLE) && (!res_valid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign op_in     = op_t'(s_tuser);
  assign full      = count == CW'(DEPTH);
  assign empty     = count == '0;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign walk_slot = ring_add(front, walk);

  assign m_tvalid = res_valid;
  assign m_tdata  = {3'd0, COUNT_W'(res_count), res_word};
  assign m_tuser  = res_status;

  always_comb begin
    we    = 1'b0;
    waddr = walk_slot;
    wdata = alu_word;
    raddr = walk_slot;
    if (accept) begin
      case (op_in)
        OP_PUSH_BACK: begin
          we    = !full;
          waddr = ring_add(front, count);
          wdata = s_tdata;
        end
        OP_PUSH_FRONT: begin
          we    = !full;
          waddr = front_dec;
          wdata = s_tdata;
        end
        OP_POP_FRONT: raddr = front;
        OP_POP_BACK:  raddr = ring_add(front, count - CW'(1));
        default:      ;
      endcase
    end else if (state == BULK_WB) begin
      we = 1'b1;
    end
  end

  fdr_ring_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  fdr_bulk_alu u_alu (
    .clk      (clk),
    .op       (bulk_op),
    .in_word  (rdata),
    .out_word (alu_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      front     <= '0;
      count     <= '0;
      walk      <= '0;
      bulk_op   <= OP_NEGATE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && m_tready) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            res_word   <= '0;
            res_status <= ST_DONE;
            res_count  <= count;
            case (op_in)
              OP_PUSH_BACK, OP_PUSH_FRONT: begin
                res_valid <= 1'b1;
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  count     <= count + CW'(1);
                  res_count <= count + CW'(1);
                  if (op_in == OP_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              OP_POP_FRONT, OP_POP_BACK: begin
                if (empty) begin
                  res_valid  <= 1'b1;
                  res_status <= ST_EMPTY;
                end else begin
                  count <= count - CW'(1);
                  state <= POP_WAIT;
                  if (op_in == OP_POP_FRONT) begin
                    front <= ring_add(front, CW'(1));
                  end
                end
              end
              OP_CLEAR: begin
                res_valid <= 1'b1;
                res_count <= '0;
                count     <= '0;
                front     <= '0;
              end
              default: begin
                bulk_op <= op_in;
                walk    <= '0;
                if (empty) begin
                  res_valid <= 1'b1;
                end else begin
                  state <= BULK_READ;
                end
              end
            endcase
          end
        end
        POP_WAIT: begin
          res_valid <= 1'b1;
          res_word  <= rdata;
          res_count <= count;
          state     <= IDLE;
        end
        BULK_READ: state <= BULK_LOAD;
        BULK_LOAD: state <= BULK_CALC;
        BULK_CALC: state <= BULK_WB;
        BULK_WB: begin
          walk <= walk + CW'(1);
          if (walk + CW'(1) == count) begin
            res_valid <= 1'b1;
            state     <= IDLE;
          end else begin
            state <= BULK_READ;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `FDR_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "count above depth")
  `FDR_ASSERT_NOW(a_full_flag, res_valid && res_status == ST_FULL, full,
                  "full status with room left")
  `FDR_ASSERT_NOW(a_empty_flag, res_valid && res_status == ST_EMPTY, empty,
                  "empty status with entries held")
  `FDR_ASSERT_NEXT(a_clear, accept && op_in == OP_CLEAR, empty && front == '0,
                   "clear left entries")

endmodule
